// ----- sv/bgfa_pkg.sv -----
// bgfa_pkg: shared types, constants and codes for the box-gated force averager.
// No dependencies; used by bgfa_div, bgfa_lane and box_gated_force_averager.
package bgfa_pkg;

  localparam int FRAME_BITS_DEF = 24;
  localparam int DATA_W         = 32;
  localparam int OUT_CNT_W      = 24;
  localparam int NUM_LANES      = 3;
  localparam int PERIOD_W       = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd6;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LEN   = 2'd1,
    KIND_MEAN  = 2'd2
  } kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic                     last_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [OUT_CNT_W-1:0]     frame_value;
    logic [OUT_CNT_W-1:0]     inside_count;
    logic signed [DATA_W-1:0] mean_x;
    logic signed [DATA_W-1:0] mean_y;
    logic signed [DATA_W-1:0] mean_z;
    logic                     final_of_run;
  } out_item_t;

  typedef struct packed {
    logic acc_en;
    logic div_go;
    logic clr;
  } lane_ctl_t;

  typedef struct packed {
    logic in_box;
    logic busy;
  } lane_sts_t;

endpackage

// ----- sv/box_gated_force_averager.sv -----
// box_gated_force_averager: top level; config registers, run tracking, result merge.
// Depends on bgfa_pkg and bgfa_lane (which holds bgfa_div).
//
//  port group | dir | handshake           | beat
//  in_*       | in  | in_valid/in_ready   | one frame (bgfa_pkg::in_item_t)
//  out_*      | out | out_valid/out_ready | one result (bgfa_pkg::out_item_t)
//  cfg_*      | in  | cfg_we              | one register write, index cfg_idx
//
// A frame with no result leaves the block idle; such frames can follow every cycle.
// A frame with results holds the input until its last result is loaded; with a mean report
// it also waits for the serial divider (one bit per cycle) before the report is loaded,
// and a run length that follows the report is loaded after it.
// Output stalls hold the result register and delay the frame's remaining results,
// and with them the input.
// Reset is synchronous; state, counters and config registers return to their reset values.
module box_gated_force_averager #(
  parameter int FRAME_BITS = bgfa_pkg::FRAME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bgfa_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bgfa_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [bgfa_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bgfa_pkg::DATA_W-1:0]       cfg_wdata
);

  localparam int NL = bgfa_pkg::NUM_LANES;
  localparam int PW = bgfa_pkg::PERIOD_W;
  localparam logic [FRAME_BITS-1:0] CNT_MAX = '1;

  // config
  logic signed [bgfa_pkg::DATA_W-1:0] box_min_r [NL];
  logic signed [bgfa_pkg::DATA_W-1:0] box_max_r [NL];
  logic [PW-1:0]                      period_r;

  // tracking state
  logic [FRAME_BITS-1:0] frame_index_r, frame_index_nxt;
  logic                  in_run_r, in_run_nxt;
  logic [FRAME_BITS-1:0] run_start_r, run_start_nxt;
  logic [FRAME_BITS-1:0] inside_total_r, inside_total_nxt;
  logic [PW-1:0]         period_cnt_r, period_cnt_nxt;

  // pending results
  bgfa_pkg::state_t      state_r, state_nxt;
  logic                  pend_start_r, pend_start_nxt;
  logic                  pend_rep_r, pend_rep_nxt;
  logic                  pend_len_r, pend_len_nxt;
  logic [FRAME_BITS-1:0] start_val_r, len_val_r, rep_cnt_r;
  logic [FRAME_BITS-1:0] len_val;

  logic                  out_valid_r, out_valid_nxt;
  bgfa_pkg::out_item_t   out_r, out_nxt;

  // lanes
  bgfa_pkg::lane_ctl_t                lane_ctl;
  bgfa_pkg::lane_sts_t                lane_sts [NL];
  logic signed [bgfa_pkg::DATA_W-1:0] lane_pos [NL];
  logic signed [bgfa_pkg::DATA_W-1:0] lane_force [NL];
  logic signed [bgfa_pkg::DATA_W-1:0] lane_mean [NL];
  logic [NL-1:0]                      inside_v, busy_v;

  logic                  acc, in_box, count_ok, rep_hit, start_evt, len_evt, any_evt;
  logic [PW:0]           pc_inc;
  logic [PW-1:0]         period_eff;
  logic [FRAME_BITS-1:0] run_start_eff, span, total_inc;

  logic                  ld, ld_final;
  bgfa_pkg::kind_t       ld_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NL; i++) begin
        box_min_r[i] <= '0;
        box_max_r[i] <= '0;
      end
      period_r <= bgfa_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        bgfa_pkg::CFG_BOX_MIN_X: box_min_r[0] <= cfg_wdata;
        bgfa_pkg::CFG_BOX_MIN_Y: box_min_r[1] <= cfg_wdata;
        bgfa_pkg::CFG_BOX_MIN_Z: box_min_r[2] <= cfg_wdata;
        bgfa_pkg::CFG_BOX_MAX_X: box_max_r[0] <= cfg_wdata;
        bgfa_pkg::CFG_BOX_MAX_Y: box_max_r[1] <= cfg_wdata;
        bgfa_pkg::CFG_BOX_MAX_Z: box_max_r[2] <= cfg_wdata;
        bgfa_pkg::CFG_PERIOD:    period_r     <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  assign lane_pos[0]   = in_data.pos_x;
  assign lane_pos[1]   = in_data.pos_y;
  assign lane_pos[2]   = in_data.pos_z;
  assign lane_force[0] = in_data.force_x;
  assign lane_force[1] = in_data.force_y;
  assign lane_force[2] = in_data.force_z;

  for (genvar g = 0; g < NL; g++) begin : g_lane
    bgfa_lane #(
      .FRAME_BITS (FRAME_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .box_min  (box_min_r[g]),
      .box_max  (box_max_r[g]),
      .pos      (lane_pos[g]),
      .force_in (lane_force[g]),
      .count    (total_inc),
      .sts      (lane_sts[g]),
      .mean     (lane_mean[g])
    );
    assign inside_v[g] = lane_sts[g].in_box;
    assign busy_v[g]   = lane_sts[g].busy;
  end

  // frame decode
  always_comb begin
    acc           = in_valid && in_ready;
    in_box        = &inside_v;
    count_ok      = in_box && (inside_total_r != CNT_MAX);
    period_eff    = (period_r == '0) ? PW'(1) : period_r;
    pc_inc        = {1'b0, period_cnt_r} + 1'b1;
    rep_hit       = count_ok && (pc_inc >= {1'b0, period_eff});
    start_evt     = in_box && !in_run_r;
    len_evt       = in_box ? in_data.last_frame : in_run_r;
    any_evt       = start_evt || rep_hit || len_evt;
    run_start_eff = start_evt ? frame_index_r : run_start_r;
    span          = frame_index_r - run_start_eff;
    len_val       = (in_box && span != CNT_MAX) ? span + 1'b1 : span;
    total_inc     = inside_total_r + 1'b1;
    lane_ctl.acc_en = acc && count_ok;
    lane_ctl.div_go = acc && rep_hit;
    lane_ctl.clr    = acc && in_data.last_frame;
  end

  always_comb begin
    frame_index_nxt  = frame_index_r;
    in_run_nxt       = in_run_r;
    run_start_nxt    = run_start_r;
    inside_total_nxt = inside_total_r;
    period_cnt_nxt   = period_cnt_r;
    if (acc) begin
      if (in_data.last_frame) begin
        frame_index_nxt  = '0;
        in_run_nxt       = 1'b0;
        run_start_nxt    = '0;
        inside_total_nxt = '0;
        period_cnt_nxt   = '0;
      end else begin
        if (frame_index_r != CNT_MAX) begin
          frame_index_nxt = frame_index_r + 1'b1;
        end
        in_run_nxt    = in_box;
        run_start_nxt = run_start_eff;
        if (count_ok) begin
          inside_total_nxt = total_inc;
          period_cnt_nxt   = rep_hit ? '0 : pc_inc[PW-1:0];
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bgfa_pkg::S_IDLE: if (acc && any_evt) state_nxt = bgfa_pkg::S_EMIT;
      bgfa_pkg::S_EMIT: if (ld && ld_final) state_nxt = bgfa_pkg::S_IDLE;
      default:          state_nxt = bgfa_pkg::S_IDLE;
    endcase
  end

  // emit selection: run start, mean report, run length
  always_comb begin
    ld       = 1'b0;
    ld_final = 1'b0;
    ld_kind  = bgfa_pkg::KIND_START;
    in_ready = 1'b0;
    case (state_r)
      bgfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      bgfa_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          if (pend_start_r) begin
            ld       = 1'b1;
            ld_kind  = bgfa_pkg::KIND_START;
            ld_final = !pend_rep_r && !pend_len_r;
          end else if (pend_rep_r) begin
            ld       = (busy_v == '0);
            ld_kind  = bgfa_pkg::KIND_MEAN;
            ld_final = !pend_len_r;
          end else if (pend_len_r) begin
            ld       = 1'b1;
            ld_kind  = bgfa_pkg::KIND_LEN;
            ld_final = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pend_start_nxt = pend_start_r;
    pend_rep_nxt   = pend_rep_r;
    pend_len_nxt   = pend_len_r;
    if (acc) begin
      pend_start_nxt = start_evt;
      pend_rep_nxt   = rep_hit;
      pend_len_nxt   = len_evt;
    end else if (ld) begin
      case (ld_kind)
        bgfa_pkg::KIND_START: pend_start_nxt = 1'b0;
        bgfa_pkg::KIND_MEAN:  pend_rep_nxt   = 1'b0;
        bgfa_pkg::KIND_LEN:   pend_len_nxt   = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.kind         = ld_kind;
    out_nxt.final_of_run = ld_final;
    case (ld_kind)
      bgfa_pkg::KIND_START: out_nxt.frame_value = bgfa_pkg::OUT_CNT_W'(start_val_r);
      bgfa_pkg::KIND_LEN:   out_nxt.frame_value = bgfa_pkg::OUT_CNT_W'(len_val_r);
      bgfa_pkg::KIND_MEAN: begin
        out_nxt.inside_count = bgfa_pkg::OUT_CNT_W'(rep_cnt_r);
        out_nxt.mean_x       = lane_mean[0];
        out_nxt.mean_y       = lane_mean[1];
        out_nxt.mean_z       = lane_mean[2];
      end
      default: ;
    endcase
    out_valid_nxt = ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bgfa_pkg::S_IDLE;
      frame_index_r  <= '0;
      in_run_r       <= 1'b0;
      run_start_r    <= '0;
      inside_total_r <= '0;
      period_cnt_r   <= '0;
      pend_start_r   <= 1'b0;
      pend_rep_r     <= 1'b0;
      pend_len_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      frame_index_r  <= frame_index_nxt;
      in_run_r       <= in_run_nxt;
      run_start_r    <= run_start_nxt;
      inside_total_r <= inside_total_nxt;
      period_cnt_r   <= period_cnt_nxt;
      pend_start_r   <= pend_start_nxt;
      pend_rep_r     <= pend_rep_nxt;
      pend_len_r     <= pend_len_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      start_val_r <= frame_index_r;
      len_val_r   <= len_val;
      rep_cnt_r   <= total_inc;
    end
    if (ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    lane_ctl.div_go |=> (&busy_v))
    else $error("mean report requested but lane dividers not running");

  a_mean_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_kind == bgfa_pkg::KIND_MEAN) |-> (busy_v == '0))
    else $error("mean loaded while a divider is still busy");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bgfa_pkg::S_IDLE) |-> !(pend_start_r || pend_rep_r || pend_len_r))
    else $error("idle with results still pending");

  a_busy_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_v != '0) |-> (state_r == bgfa_pkg::S_EMIT && pend_rep_r))
    else $error("divider running without a pending mean report");

endmodule

// ----- sv/bgfa_div.sv -----
// bgfa_div: bit-serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero. Depends on bgfa_pkg.
module bgfa_div #(
  parameter int SW = bgfa_pkg::DATA_W + bgfa_pkg::FRAME_BITS_DEF,
  parameter int DW = bgfa_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic signed [SW-1:0]             dividend,
  input  logic [DW-1:0]                    divisor,
  output logic                             busy,
  output logic signed [bgfa_pkg::DATA_W-1:0] quot
);

  localparam int CNT_W = $clog2(SW + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]    quot_r, quot_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r;
  logic             neg_r;
  logic [DW:0]      sh;
  logic             ge;
  logic [SW-1:0]    mag;
  logic [bgfa_pkg::DATA_W-1:0] q_lo;

  always_comb begin
    mag      = dividend[SW-1] ? $unsigned(-dividend) : $unsigned(dividend);
    sh       = {rem_r, quot_r[SW-1]};
    ge       = sh >= {1'b0, den_r};
    rem_nxt  = ge ? DW'(sh - {1'b0, den_r}) : sh[DW-1:0];
    quot_nxt = {quot_r[SW-2:0], ge};
    cnt_nxt  = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (go) begin
      cnt_r <= CNT_W'(SW);
    end else if (busy) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot_r <= mag;
      rem_r  <= '0;
      den_r  <= divisor;
      neg_r  <= dividend[SW-1];
    end else if (busy) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy = cnt_r != '0;
  assign q_lo = quot_r[bgfa_pkg::DATA_W-1:0];
  assign quot = neg_r ? $signed(-q_lo) : $signed(q_lo);

endmodule

// ----- sv/bgfa_lane.sv -----
// bgfa_lane: one axis: inclusive box test, running force sum and mean divider.
// Depends on bgfa_pkg and bgfa_div.
module bgfa_lane #(
  parameter int FRAME_BITS = bgfa_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bgfa_pkg::lane_ctl_t                 ctl,
  input  logic signed [bgfa_pkg::DATA_W-1:0]  box_min,
  input  logic signed [bgfa_pkg::DATA_W-1:0]  box_max,
  input  logic signed [bgfa_pkg::DATA_W-1:0]  pos,
  input  logic signed [bgfa_pkg::DATA_W-1:0]  force_in,
  input  logic [FRAME_BITS-1:0]               count,
  output bgfa_pkg::lane_sts_t                 sts,
  output logic signed [bgfa_pkg::DATA_W-1:0]  mean
);

  localparam int SW = bgfa_pkg::DATA_W + FRAME_BITS;

  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 div_busy;

  assign sum_nxt = sum_r + {{FRAME_BITS{force_in[bgfa_pkg::DATA_W-1]}}, force_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.clr) begin
      sum_r <= '0;
    end else if (ctl.acc_en) begin
      sum_r <= sum_nxt;
    end
  end

  bgfa_div #(
    .SW (SW),
    .DW (FRAME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (ctl.div_go),
    .dividend (sum_nxt),
    .divisor  (count),
    .busy     (div_busy),
    .quot     (mean)
  );

  assign sts.in_box = (pos >= box_min) && (pos <= box_max);
  assign sts.busy   = div_busy;

endmodule

// ----- sim/bgfa_result_checker.sv -----
// bgfa_result_checker: follows the frame, result and register ports of the averager,
// predicts the results of every accepted frame and compares them beat by beat.
// Depends on bgfa_pkg only.
`timescale 1ns / 100ps
module bgfa_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  bgfa_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  bgfa_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [bgfa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bgfa_pkg::DATA_W-1:0]    cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int CW = bgfa_pkg::FRAME_BITS_DEF;
  localparam int DW = bgfa_pkg::DATA_W;
  localparam int NL = bgfa_pkg::NUM_LANES;
  localparam int PW = bgfa_pkg::PERIOD_W;
  localparam logic [CW-1:0] CNT_SAT = '1;

  logic signed [DW-1:0] box_lo [NL];
  logic signed [DW-1:0] box_hi [NL];
  logic [PW-1:0]        period_reg;

  logic [CW-1:0] frame_idx;
  logic [CW-1:0] run_first;
  logic [CW-1:0] inside_cnt;
  logic          in_run;
  logic [PW:0]   period_cnt;
  longint        force_acc [NL];

  bgfa_pkg::out_item_t pending_results [$];

  function automatic void clear_tracking();
    int a;
    frame_idx  = '0;
    run_first  = '0;
    inside_cnt = '0;
    in_run     = 1'b0;
    period_cnt = '0;
    for (a = 0; a < NL; a++) force_acc[a] = 0;
  endfunction

  function automatic void predict_frame(bgfa_pkg::in_item_t f);
    logic signed [DW-1:0] pos [NL];
    logic signed [DW-1:0] frc [NL];
    bgfa_pkg::out_item_t  res [3];
    logic [PW:0]          period;
    logic [CW-1:0]        len;
    longint               q;
    logic                 hit;
    int                   n;
    int                   a;
    pos    = '{f.pos_x, f.pos_y, f.pos_z};
    frc    = '{f.force_x, f.force_y, f.force_z};
    hit    = 1'b1;
    n      = 0;
    period = (period_reg == '0) ? (PW+1)'(1) : {1'b0, period_reg};
    for (a = 0; a < NL; a++)
      if (pos[a] < box_lo[a] || pos[a] > box_hi[a]) hit = 1'b0;
    if (hit) begin
      if (!in_run) begin
        in_run = 1'b1;
        run_first = frame_idx;
        res[n] = '0;
        res[n].kind = bgfa_pkg::KIND_START;
        res[n].frame_value = frame_idx;
        n++;
      end
      // saturated inside count: no more sums, counts or reports
      if (inside_cnt != CNT_SAT) begin
        for (a = 0; a < NL; a++) force_acc[a] += frc[a];
        inside_cnt++;
        period_cnt++;
        if (period_cnt >= period) begin
          period_cnt = '0;
          res[n] = '0;
          res[n].kind = bgfa_pkg::KIND_MEAN;
          res[n].inside_count = inside_cnt;
          q = force_acc[0] / longint'(inside_cnt);
          res[n].mean_x = q[DW-1:0];
          q = force_acc[1] / longint'(inside_cnt);
          res[n].mean_y = q[DW-1:0];
          q = force_acc[2] / longint'(inside_cnt);
          res[n].mean_z = q[DW-1:0];
          n++;
        end
      end
      if (f.last_frame) begin
        len = frame_idx - run_first;
        if (len != CNT_SAT) len++;
        res[n] = '0;
        res[n].kind = bgfa_pkg::KIND_LEN;
        res[n].frame_value = len;
        n++;
      end
    end else if (in_run) begin
      in_run = 1'b0;
      res[n] = '0;
      res[n].kind = bgfa_pkg::KIND_LEN;
      res[n].frame_value = frame_idx - run_first;
      n++;
    end
    if (n > 0) res[n-1].final_of_run = 1'b1;
    for (a = 0; a < n; a++) pending_results.push_back(res[a]);
    if (f.last_frame) clear_tracking();
    else if (frame_idx != CNT_SAT) frame_idx++;
  endfunction

  function automatic void check_field(string name, logic [DW-1:0] want,
                                      logic [DW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(bgfa_pkg::out_item_t got);
    bgfa_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result beat, expected none, got %h", $time, got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", DW'(want.kind), DW'(got.kind));
      check_field("frame_value", DW'(want.frame_value), DW'(got.frame_value));
      check_field("inside_count", DW'(want.inside_count), DW'(got.inside_count));
      check_field("mean_x", want.mean_x, got.mean_x);
      check_field("mean_y", want.mean_y, got.mean_y);
      check_field("mean_z", want.mean_z, got.mean_z);
      check_field("final_of_run", DW'(want.final_of_run), DW'(got.final_of_run));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NL; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      period_reg = bgfa_pkg::PERIOD_RESET;
      mismatches = 0;
      clear_tracking();
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          bgfa_pkg::CFG_BOX_MIN_X: box_lo[0] = cfg_wdata;
          bgfa_pkg::CFG_BOX_MIN_Y: box_lo[1] = cfg_wdata;
          bgfa_pkg::CFG_BOX_MIN_Z: box_lo[2] = cfg_wdata;
          bgfa_pkg::CFG_BOX_MAX_X: box_hi[0] = cfg_wdata;
          bgfa_pkg::CFG_BOX_MAX_Y: box_hi[1] = cfg_wdata;
          bgfa_pkg::CFG_BOX_MAX_Z: box_hi[2] = cfg_wdata;
          bgfa_pkg::CFG_PERIOD:    period_reg = cfg_wdata[PW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_frame(in_data);
      if (out_valid && out_ready) compare_result(out_data);
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- sim/box_gated_force_averager_tb.sv -----
// box_gated_force_averager_tb: clock, reset, frame and register stimulus, output back-pressure.
// Checking is done by bgfa_result_checker; depends on bgfa_pkg and the averager RTL.
`timescale 1ns / 100ps
module box_gated_force_averager_tb;

  localparam int     DW          = bgfa_pkg::DATA_W;
  localparam int     PW          = bgfa_pkg::PERIOD_W;
  localparam int     SETTLE      = DW + bgfa_pkg::FRAME_BITS_DEF + 1 + 16;
  localparam int     HOLD_CYCLES = 400;
  localparam int     IDLE_LIMIT  = 2000;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam longint Q_MAX       = 64'sd2147483647;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  bgfa_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  bgfa_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [bgfa_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [DW-1:0]                  cfg_wdata;
  int                             mismatches;
  int                             outstanding;

  logic                 tx_burst;
  logic                 rx_burst;
  logic                 hold_req;
  logic                 hold_taken;
  int                   stall_left;
  logic signed [31:0]   box_lo [3];
  logic signed [31:0]   box_hi [3];

  box_gated_force_averager i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bgfa_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bgfa_pkg::in_item_t frame_of(logic [31:0] px, py, pz, fx, fy, fz,
                                                  logic last);
    bgfa_pkg::in_item_t f;
    f.pos_x      = px;
    f.pos_y      = py;
    f.pos_z      = pz;
    f.force_x    = fx;
    f.force_y    = fy;
    f.force_z    = fz;
    f.last_frame = last;
    return f;
  endfunction

  function automatic logic [31:0] pick_between(longint lo, longint hi);
    logic [63:0] r;
    longint      v;
    r = {$urandom, $urandom};
    v = lo + longint'(r % (hi - lo + 1));
    return v[31:0];
  endfunction

  // cls: -1 draws a class; 0 inside, 1 outside on one axis
  function automatic bgfa_pkg::in_item_t random_frame(int cls);
    logic [31:0] p [3];
    logic [31:0] fc [3];
    logic        tiny;
    longint      lo, hi;
    int          a, ax;
    if (cls < 0) cls = $urandom_range(0, 19);
    else if (cls == 1) cls = 15;
    tiny = ($urandom_range(0, 3) == 0);
    for (a = 0; a < 3; a++) begin
      lo = box_lo[a];
      hi = box_hi[a];
      if (cls >= 18 || lo > hi) p[a] = $urandom;
      else if (cls >= 12 && cls < 15) p[a] = $urandom_range(0, 1) ? box_lo[a] : box_hi[a];
      else p[a] = pick_between(lo, hi);
      fc[a] = $urandom;
      if (tiny) fc[a] = {{24{fc[a][7]}}, fc[a][7:0]};
    end
    if (cls >= 15 && cls < 18) begin
      ax = $urandom_range(0, 2);
      lo = box_lo[ax];
      hi = box_hi[ax];
      if (lo > Q_MIN && ($urandom_range(0, 1) == 0 || hi == Q_MAX))
        p[ax] = $urandom_range(0, 1) ? pick_between(Q_MIN, lo - 1) : box_lo[ax] - 1;
      else if (hi < Q_MAX)
        p[ax] = $urandom_range(0, 1) ? pick_between(hi + 1, Q_MAX) : box_hi[ax] + 1;
    end
    return frame_of(p[0], p[1], p[2], fc[0], fc[1], fc[2], $urandom_range(0, 11) == 0);
  endfunction

  task automatic send_frame(bgfa_pkg::in_item_t f);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering frames until every predicted result is back, then let the divider settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [bgfa_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_registers(logic [PW-1:0] per);
    write_reg(bgfa_pkg::CFG_BOX_MIN_X, box_lo[0]);
    write_reg(bgfa_pkg::CFG_BOX_MIN_Y, box_lo[1]);
    write_reg(bgfa_pkg::CFG_BOX_MIN_Z, box_lo[2]);
    write_reg(bgfa_pkg::CFG_BOX_MAX_X, box_hi[0]);
    write_reg(bgfa_pkg::CFG_BOX_MAX_Y, box_hi[1]);
    write_reg(bgfa_pkg::CFG_BOX_MAX_Z, box_hi[2]);
    write_reg(bgfa_pkg::CFG_PERIOD, {{(DW-PW){1'b0}}, per});
    cfg_we <= 1'b0;
  endtask

  task automatic random_box();
    logic [PW-1:0] per;
    longint        c, w, lo, hi;
    int            shape, a, ax;
    shape = $urandom_range(0, 5);
    ax    = $urandom_range(0, 2);
    for (a = 0; a < 3; a++) begin
      c  = longint'($signed($urandom));
      w  = longint'($urandom >> $urandom_range(1, 31)) + 1;
      lo = c - w;
      hi = c + w;
      if (lo < Q_MIN) lo = Q_MIN;
      if (hi > Q_MAX) hi = Q_MAX;
      if (shape == 0) begin
        lo = Q_MIN;
        hi = Q_MAX;
      end else if (shape == 1) begin
        lo = c;
        hi = c;
      end
      if (shape == 5 && a == ax) begin
        box_lo[a] = hi[31:0];
        box_hi[a] = lo[31:0];
      end else begin
        box_lo[a] = lo[31:0];
        box_hi[a] = hi[31:0];
      end
    end
    case ($urandom_range(0, 9))
      0:       per = '0;
      1:       per = 16'd1;
      2:       per = 16'hFFFF;
      3:       per = bgfa_pkg::PERIOD_RESET;
      default: per = PW'($urandom_range(2, 8));
    endcase
    load_registers(per);
  endtask

  // receiver: random stalls per beat, bursts without stalls, and one long hold-off
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    rx_burst   = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : $urandom_range(0, 13);
      end else if (out_ready && !rx_burst && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("[box_gated_force_averager] ERROR");
    $finish;
  end

  initial begin
    int sent, n, i;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    tx_burst  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset box is the single point at the origin, period 1000
    send_frame(frame_of(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 1'b0));
    send_frame(frame_of(32'h0001_0000, 0, 0, 1, 2, 3, 1'b0));
    drain();

    // +-100.0 box, bounds inclusive, period 2
    box_lo = '{32'hFF9C_0000, 32'hFF9C_0000, 32'hFF9C_0000};
    box_hi = '{32'h0064_0000, 32'h0064_0000, 32'h0064_0000};
    load_registers(16'd2);
    send_frame(frame_of(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_frame(frame_of(32'hFF9C_0000, 32'h0064_0000, 32'hFF9C_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_frame(frame_of(32'h0064_0001, 0, 0, 1, 2, 3, 1'b0));
    send_frame(frame_of(0, 32'hFF9B_FFFF, 0, 4, 5, 6, 1'b0));
    send_frame(frame_of(0, 0, 32'h0064_0001, 7, 8, 9, 1'b0));
    send_frame(frame_of(32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
                        32'hFFFF_FFFF, 0, 1, 1'b0));
    send_frame(frame_of(32'hFF9C_0000, 32'hFF9C_0000, 32'hFF9C_0000,
                        32'h0003_8000, 32'hFFFC_8000, 32'h1234_5678, 1'b1));
    send_frame(frame_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b1));
    send_frame(frame_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5, 5, 5, 1'b0));
    drain();

    // whole range inside, period 0 behaves as 1
    box_lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    box_hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_registers(16'd0);
    send_frame(frame_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_frame(frame_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_frame(frame_of(32'hFFFF_FFFF, 0, 1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
    send_frame(frame_of(0, 0, 0, 32'hFFFF_FFF9, 7, 32'h0000_0003, 1'b1));
    drain();

    // min above max on x: nothing is ever inside
    box_lo = '{32'd5, 32'h8000_0000, 32'h8000_0000};
    box_hi = '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    load_registers(16'hFFFF);
    send_frame(frame_of(0, 0, 0, 1, 1, 1, 1'b0));
    send_frame(frame_of(32'd5, 0, 0, 1, 1, 1, 1'b0));
    send_frame(frame_of(32'hFFFF_FFFB, 0, 0, 1, 1, 1, 1'b1));
    drain();

    sent = 0;
    while (sent < 100) begin
      random_box();
      tx_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 25);
      for (i = 0; i < n; i++) send_frame(random_frame(-1));
      sent += n;
      drain();
      if (!hold_taken) begin
        // output held off while frames keep coming; frames alternate inside and outside the box
        box_lo = '{-32'sd1000, -32'sd1000, -32'sd1000};
        box_hi = '{32'sd1000, 32'sd1000, 32'sd1000};
        load_registers(16'd3);
        tx_burst = 1'b1;
        hold_req <= 1'b1;
        for (i = 0; i < 24; i++) send_frame(random_frame(i % 2));
        sent += 24;
        drain();
      end
    end

    if (mismatches == 0) $display("[box_gated_force_averager] OK");
    else $display("[box_gated_force_averager] ERROR");
    $finish;
  end

endmodule
